### src/ptt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

	localparam int SLOTS_DEF     = 32;
	localparam int TIME_BITS_DEF = 48;

	localparam logic [2:0] MODE_START   = 3'd0;
	localparam logic [2:0] MODE_RESTART = 3'd1;
	localparam logic [2:0] MODE_DELAY   = 3'd2;
	localparam logic [2:0] MODE_FORCE   = 3'd3;
	localparam logic [2:0] MODE_KILL    = 3'd4;
	localparam logic [2:0] MODE_SCAN    = 3'd5;

	localparam logic [2:0] KIND_STARTED = 3'd0;
	localparam logic [2:0] KIND_FIRED   = 3'd1;
	localparam logic [2:0] KIND_MOVED   = 3'd2;
	localparam logic [2:0] KIND_DONE    = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CMD_MOD,
		ST_SC_RD,
		ST_SC_EVAL,
		ST_SC_MOVE,
		ST_FI_RD,
		ST_FI_EVAL,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### src/periodic_timer_table.sv
// Periodic timer table.
// Commands arrive on the s_ group: s_tuser carries the mode, s_tdata the
// time, timer id, slot and amount. Results leave on the m_ group: m_tuser
// carries the result kind, m_tdata the timer id, slot and live count, and
// m_tlast marks the final result of a command.
// All entries sit in one single-port table with a registered read; each
// command is a read-modify-write sequence on it, one command at a time.
// Start and the error cases emit their result from the execute state once
// the result register is free; restart, delay, force and kill first read
// the entry there and emit from the modify state. A scan walks the table
// twice, a compaction pass and then a fire pass, reading one entry at a
// time through the table read port, with a read state and an evaluate state.
// It emits moved results, fired results and one done result, up to SLOTS+1
// transactions.
// s_tready is high only between commands; a finished result waiting in the
// output register does not block the next command from being taken.
// When m_tready is low the sequencer holds at any step that must emit until
// the result register drains, so no result is lost or repeated.
// Reset clears the occupied count; the table needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_table
	import ptt_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF,
	localparam int SLOT_W   = $clog2(SLOTS),
	localparam int CNT_W    = $clog2(SLOTS + 1),
	localparam int IN_W     = TIME_BITS + 16 + SLOT_W + 32,
	localparam int IN_DW    = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W    = 16 + SLOT_W + CNT_W,
	localparam int OUT_DW   = ((OUT_W + 7) / 8) * 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// now, timer_id, slot, amount (lowest bits first), zero padded
	input  wire logic [IN_DW-1:0]    s_tdata,
	// mode
	input  wire logic [2:0]          s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// out_timer_id, out_slot, live_count (lowest bits first), zero padded
	output logic [OUT_DW-1:0]        m_tdata,
	// kind
	output logic [2:0]               m_tuser,
	output logic                     m_tlast
);

	localparam int SUM_W  = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
	localparam logic [TIME_BITS-1:0] TMAX = '1;

	typedef struct packed {
		logic                 dead;
		logic                 due;
		logic [15:0]          id;
		logic [31:0]          period;
		logic [TIME_BITS-1:0] deadline;
	} entry_t;

	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
			input logic [31:0] b);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(a) + SUM_W'(b);
		if (sum >= SUM_W'(TMAX)) begin
			return TMAX;
		end
		return sum[TIME_BITS-1:0];
	endfunction

	state_t st_q, st_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;

	logic [2:0]           mode_q;
	logic [TIME_BITS-1:0] now_q;
	logic [15:0]          tid_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [31:0]          amt_q;

	entry_t mem [SLOTS];
	entry_t rdata_q;
	logic              we, re;
	logic [SLOT_W-1:0] waddr, raddr;
	entry_t            wdata;

	logic              emit;
	logic [2:0]        e_kind;
	logic [15:0]       e_id;
	logic [SLOT_W-1:0] e_slot;
	logic              e_last;

	logic              m_tvalid_q;
	logic [2:0]        out_kind_q;
	logic [15:0]       out_id_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [CNT_W-1:0]  out_live_q;
	logic              out_last_q;

	logic             out_free, accept, full, slot_ok, idx_lt;
	logic [CNT_W-1:0] back;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q >= CNT_W'(SLOTS));
	assign slot_ok  = (CNT_W'(slot_q) < count_q);
	assign idx_lt   = (idx_q < count_q);
	assign back     = count_q - CNT_W'(1);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) st_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					if (mode_q == MODE_SCAN) begin
						st_d = ST_SC_RD;
					end else if ((mode_q == MODE_RESTART || mode_q == MODE_DELAY ||
							mode_q == MODE_FORCE || mode_q == MODE_KILL) && slot_ok) begin
						st_d = ST_CMD_MOD;
					end else begin
						st_d = ST_IDLE;
					end
				end
			end
			ST_CMD_MOD: begin
				if (out_free) st_d = ST_IDLE;
			end
			ST_SC_RD: begin
				st_d = idx_lt ? ST_SC_EVAL : ST_FI_RD;
			end
			ST_SC_EVAL: begin
				if (!rdata_q.dead) begin
					st_d = ST_SC_RD;
				end else if (back != idx_q) begin
					st_d = ST_SC_MOVE;
				end else begin
					st_d = ST_FI_RD;
				end
			end
			ST_SC_MOVE: begin
				if (out_free) st_d = ST_SC_RD;
			end
			ST_FI_RD: begin
				st_d = idx_lt ? ST_FI_EVAL : ST_DONE;
			end
			ST_FI_EVAL: begin
				if (!rdata_q.due || out_free) st_d = ST_FI_RD;
			end
			ST_DONE: begin
				if (out_free) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we      = 1'b0;
		waddr   = '0;
		wdata   = rdata_q;
		re      = 1'b0;
		raddr   = '0;
		emit    = 1'b0;
		e_kind  = KIND_DONE;
		e_id    = '0;
		e_slot  = '0;
		e_last  = 1'b1;
		count_d = count_q;
		idx_d   = idx_q;
		unique case (st_q)
			ST_IDLE: begin
				idx_d = '0;
			end
			ST_EXEC: begin
				if (out_free) begin
					priority if (mode_q == MODE_START) begin
						emit = 1'b1;
						e_id = tid_q;
						if (full) begin
							e_kind = KIND_ERROR;
						end else begin
							we             = 1'b1;
							waddr          = count_q[SLOT_W-1:0];
							wdata.dead     = 1'b0;
							wdata.due      = 1'b0;
							wdata.id       = tid_q;
							wdata.period   = amt_q;
							wdata.deadline = sat_add(now_q, amt_q);
							count_d        = count_q + CNT_W'(1);
							e_kind         = KIND_STARTED;
							e_slot         = count_q[SLOT_W-1:0];
						end
					end else if (mode_q == MODE_RESTART || mode_q == MODE_DELAY ||
							mode_q == MODE_FORCE || mode_q == MODE_KILL) begin
						if (slot_ok) begin
							re    = 1'b1;
							raddr = slot_q;
						end else begin
							emit   = 1'b1;
							e_kind = KIND_ERROR;
							e_slot = slot_q;
						end
					end else if (mode_q == MODE_SCAN) begin
						idx_d = '0;
					end else begin
						emit   = 1'b1;
						e_kind = KIND_ERROR;
					end
				end
			end
			ST_CMD_MOD: begin
				if (out_free) begin
					we    = 1'b1;
					waddr = slot_q;
					unique case (mode_q)
						MODE_RESTART: wdata.deadline = sat_add(now_q, rdata_q.period);
						MODE_DELAY:   wdata.deadline = sat_add(rdata_q.deadline, amt_q);
						MODE_FORCE:   wdata.deadline = now_q;
						default:      wdata.dead     = 1'b1;
					endcase
					emit   = 1'b1;
					e_kind = KIND_DONE;
					e_id   = rdata_q.id;
					e_slot = slot_q;
				end
			end
			ST_SC_RD: begin
				if (idx_lt) begin
					re    = 1'b1;
					raddr = idx_q[SLOT_W-1:0];
				end else begin
					idx_d = '0;
				end
			end
			ST_SC_EVAL: begin
				if (!rdata_q.dead) begin
					we        = 1'b1;
					waddr     = idx_q[SLOT_W-1:0];
					wdata.due = (now_q >= rdata_q.deadline);
					idx_d     = idx_q + CNT_W'(1);
				end else begin
					count_d = back;
					if (back != idx_q) begin
						re    = 1'b1;
						raddr = back[SLOT_W-1:0];
					end else begin
						idx_d = '0;
					end
				end
			end
			ST_SC_MOVE: begin
				if (out_free) begin
					we     = 1'b1;
					waddr  = idx_q[SLOT_W-1:0];
					emit   = 1'b1;
					e_kind = KIND_MOVED;
					e_id   = rdata_q.id;
					e_slot = idx_q[SLOT_W-1:0];
					e_last = 1'b0;
				end
			end
			ST_FI_RD: begin
				if (idx_lt) begin
					re    = 1'b1;
					raddr = idx_q[SLOT_W-1:0];
				end
			end
			ST_FI_EVAL: begin
				if (!rdata_q.due) begin
					idx_d = idx_q + CNT_W'(1);
				end else if (out_free) begin
					we             = 1'b1;
					waddr          = idx_q[SLOT_W-1:0];
					wdata.due      = 1'b0;
					wdata.deadline = sat_add(rdata_q.deadline, rdata_q.period);
					emit           = 1'b1;
					e_kind         = KIND_FIRED;
					e_id           = rdata_q.id;
					e_slot         = idx_q[SLOT_W-1:0];
					e_last         = 1'b0;
					idx_d          = idx_q + CNT_W'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					emit   = 1'b1;
					e_kind = KIND_DONE;
				end
			end
			default: begin
				idx_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q    <= st_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_tuser;
			now_q  <= s_tdata[TIME_BITS-1:0];
			tid_q  <= s_tdata[TIME_BITS +: 16];
			slot_q <= s_tdata[TIME_BITS+16 +: SLOT_W];
			amt_q  <= s_tdata[TIME_BITS+16+SLOT_W +: 32];
		end
		if (emit) begin
			out_kind_q <= e_kind;
			out_id_q   <= e_id;
			out_slot_q <= e_slot;
			out_live_q <= count_d;
			out_last_q <= e_last;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DW'({out_live_q, out_slot_q, out_id_q});
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("occupied count exceeds table size");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (CNT_W'(waddr) < count_d))
		else $error("table write outside occupied slots");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result register overwritten while held");

	a_shrink_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q < $past(count_q)) |-> ($past(st_q) == ST_SC_EVAL))
		else $error("occupied count dropped outside compaction");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("command taken while another is in progress");
`endif

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ptt_pkg::*;

	localparam int SLOTS = 32;
	localparam int IN_W = 104;
	localparam int OUT_W = 32;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [2:0] MODE_BAD_LO = 3'd6;
	localparam logic [2:0] MODE_BAD_HI = 3'd7;
	localparam int RANDOM_ITEMS = 200;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		logic [2:0]  mode;
		logic [47:0] now;
		logic [15:0] timer_id;
		logic [4:0]  slot;
		logic [31:0] amount;
		logic        hold;
	} timer_cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] timer_id;
		logic [4:0]  slot;
		logic [5:0]  live;
		logic        is_last;
	} timer_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	wire              s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic [2:0]       s_tuser = '0;
	wire              m_tvalid;
	logic             m_tready = 1'b0;
	wire [OUT_W-1:0]  m_tdata;
	wire [2:0]        m_tuser;
	wire              m_tlast;

	periodic_timer_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	timer_cmd_t    command_backlog[$];
	timer_result_t awaited_results[$];

	// predicted table contents
	logic [47:0] deadline_mem [SLOTS];
	logic [31:0] period_mem [SLOTS];
	logic [15:0] id_mem [SLOTS];
	logic        dead_mem [SLOTS];
	int          table_live = 0;

	// occupancy as seen by the stimulus generator
	int               plan_live = 0;
	logic [SLOTS-1:0] plan_dead = '0;
	int               n_planned = 0;

	int n_accepted = 0;
	int n_expected = 0;
	int n_received = 0;
	int result_total = 0;
	int n_errors = 0;
	int quiet_cycles = 0;

	timer_cmd_t cur_cmd;
	int         gap_left;
	int         stall_left;
	bit         calm_sender;
	bit         calm_receiver;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [47:0] sum_saturated(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, TIME_MAX}) ? TIME_MAX : s[47:0];
	endfunction

	function automatic timer_result_t make_result(input logic [2:0] kind,
			input logic [15:0] tid, input logic [4:0] slot);
		timer_result_t r;
		r.kind = kind;
		r.timer_id = tid;
		r.slot = slot;
		r.live = 6'(table_live);
		r.is_last = 1'b0;
		return r;
	endfunction

	task automatic apply_timer_command(input timer_cmd_t c);
		timer_result_t batch[$];
		bit            due [SLOTS];
		int            i;
		int            back;
		case (c.mode)
			MODE_START: begin
				if (table_live >= SLOTS) begin
					batch.push_back(make_result(KIND_ERROR, c.timer_id, 5'd0));
				end else begin
					id_mem[table_live] = c.timer_id;
					period_mem[table_live] = c.amount;
					deadline_mem[table_live] = sum_saturated(c.now, {16'd0, c.amount});
					dead_mem[table_live] = 1'b0;
					table_live++;
					batch.push_back(make_result(KIND_STARTED, c.timer_id, 5'(table_live - 1)));
				end
			end
			MODE_RESTART, MODE_DELAY, MODE_FORCE, MODE_KILL: begin
				if (int'(c.slot) >= table_live) begin
					batch.push_back(make_result(KIND_ERROR, 16'd0, c.slot));
				end else begin
					case (c.mode)
						MODE_RESTART: deadline_mem[c.slot] =
							sum_saturated(c.now, {16'd0, period_mem[c.slot]});
						MODE_DELAY: deadline_mem[c.slot] =
							sum_saturated(deadline_mem[c.slot], {16'd0, c.amount});
						MODE_FORCE: deadline_mem[c.slot] = c.now;
						default: dead_mem[c.slot] = 1'b1;
					endcase
					batch.push_back(make_result(KIND_DONE, id_mem[c.slot], c.slot));
				end
			end
			MODE_SCAN: begin
				i = 0;
				while (i < table_live) begin
					if (dead_mem[i]) begin
						back = table_live - 1;
						table_live = back;
						if (back != i) begin
							id_mem[i] = id_mem[back];
							period_mem[i] = period_mem[back];
							deadline_mem[i] = deadline_mem[back];
							dead_mem[i] = dead_mem[back];
							dead_mem[back] = 1'b0;
							batch.push_back(make_result(KIND_MOVED, id_mem[i], 5'(i)));
						end else begin
							dead_mem[i] = 1'b0;
						end
					end else begin
						due[i] = (c.now >= deadline_mem[i]);
						i++;
					end
				end
				for (i = 0; i < table_live; i++) begin
					if (due[i]) begin
						deadline_mem[i] = sum_saturated(deadline_mem[i], {16'd0, period_mem[i]});
						batch.push_back(make_result(KIND_FIRED, id_mem[i], 5'(i)));
					end
				end
				batch.push_back(make_result(KIND_DONE, 16'd0, 5'd0));
			end
			default: batch.push_back(make_result(KIND_ERROR, 16'd0, 5'd0));
		endcase
		batch[batch.size() - 1].is_last = 1'b1;
		foreach (batch[k]) awaited_results.push_back(batch[k]);
		result_total += batch.size();
	endtask

	task automatic queue_command(input logic [2:0] mode, input logic [47:0] now,
			input logic [15:0] tid, input logic [4:0] slot, input logic [31:0] amount,
			input logic hold);
		timer_cmd_t c;
		int         i;
		int         drop;
		c.mode = mode;
		c.now = now;
		c.timer_id = tid;
		c.slot = slot;
		c.amount = amount;
		c.hold = hold;
		command_backlog.push_back(c);
		n_planned++;
		drop = 0;
		case (mode)
			MODE_START: begin
				if (plan_live < SLOTS) begin
					plan_dead[plan_live] = 1'b0;
					plan_live++;
				end
			end
			MODE_KILL: begin
				if (int'(slot) < plan_live) plan_dead[slot] = 1'b1;
			end
			MODE_SCAN: begin
				for (i = 0; i < plan_live; i++) begin
					if (plan_dead[i]) drop++;
				end
				plan_live -= drop;
				plan_dead = '0;
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string what, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			n_errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit busy;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			gap_left = 0;
			calm_sender = 1'b0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				apply_timer_command(cur_cmd);
				n_accepted <= n_accepted + 1;
				n_expected <= result_total;
				busy = 1'b0;
				if ($urandom_range(0, 15) == 0) calm_sender = !calm_sender;
				gap_left = calm_sender ? 0 : $urandom_range(0, 17);
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (command_backlog.size() > 0 &&
						!(command_backlog[0].hold && n_received != result_total)) begin
					cur_cmd = command_backlog.pop_front();
					s_tdata <= {3'b000, cur_cmd.amount, cur_cmd.slot, cur_cmd.timer_id,
						cur_cmd.now};
					s_tuser <= cur_cmd.mode;
					busy = 1'b1;
				end
			end
			s_tvalid <= busy;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		timer_result_t want;
		bit            ready_next;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			calm_receiver = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_received <= n_received + 1;
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d tdata %h",
						$time, m_tuser, m_tdata);
					n_errors++;
				end else begin
					want = awaited_results.pop_front();
					check_field("kind", want.kind, m_tuser);
					check_field("timer_id", want.timer_id, m_tdata[15:0]);
					check_field("slot", want.slot, m_tdata[20:16]);
					check_field("live_count", want.live, m_tdata[26:21]);
					check_field("last", want.is_last, m_tlast);
				end
				if ($urandom_range(0, 15) == 0) calm_receiver = !calm_receiver;
				stall_left = calm_receiver ? 0 : $urandom_range(0, 17);
			end
			ready_next = 1'b1;
			if (stall_left > 0) begin
				stall_left--;
				ready_next = 1'b0;
			end
			m_tready <= ready_next;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		logic [47:0] clock_ms;
		logic [47:0] wide;
		logic [15:0] tid;
		logic [4:0]  ok_slot;
		logic [4:0]  bad_slot;
		logic [31:0] period;
		logic [2:0]  slot_modes [4];
		logic        hold;
		int          n;
		int          pick;
		int          k;

		slot_modes = '{MODE_RESTART, MODE_DELAY, MODE_FORCE, MODE_KILL};

		queue_command(MODE_SCAN, 48'd0, 16'd0, 5'd0, 32'd0, 1'b0);
		queue_command(MODE_RESTART, 48'd0, 16'd0, 5'd0, 32'd0, 1'b0);
		queue_command(MODE_START, 48'd0, 16'hFFFF, 5'd31, 32'd0, 1'b0);
		queue_command(MODE_START, TIME_MAX - 48'd5, 16'h0000, 5'd0, 32'hFFFF_FFFF, 1'b0);
		queue_command(MODE_START, 48'd100, 16'h1234, 5'd0, 32'd10, 1'b0);
		queue_command(MODE_DELAY, 48'd0, 16'd0, 5'd1, 32'hFFFF_FFFF, 1'b0);
		queue_command(MODE_FORCE, 48'd105, 16'd0, 5'd2, 32'd0, 1'b0);
		queue_command(MODE_RESTART, 48'd50, 16'd0, 5'd2, 32'd0, 1'b0);
		queue_command(MODE_KILL, 48'd0, 16'd0, 5'd0, 32'd0, 1'b0);
		queue_command(MODE_KILL, 48'd0, 16'd0, 5'd2, 32'd0, 1'b0);
		queue_command(MODE_SCAN, TIME_MAX, 16'd0, 5'd0, 32'd0, 1'b0);
		queue_command(MODE_BAD_LO, TIME_MAX, 16'hFFFF, 5'd31, 32'hFFFF_FFFF, 1'b0);
		queue_command(MODE_BAD_HI, 48'd0, 16'd0, 5'd0, 32'd0, 1'b0);
		queue_command(MODE_KILL, 48'd0, 16'd0, 5'd31, 32'd0, 1'b0);
		queue_command(MODE_DELAY, 48'd0, 16'd0, 5'd0, 32'd5, 1'b0);
		queue_command(MODE_KILL, 48'd0, 16'd0, 5'd0, 32'd0, 1'b0);
		queue_command(MODE_SCAN, 48'd0, 16'd0, 5'd0, 32'd0, 1'b0);
		queue_command(MODE_START, 48'd7, 16'hAAAA, 5'd0, 32'd3, 1'b0);
		queue_command(MODE_SCAN, 48'd9, 16'd0, 5'd0, 32'd0, 1'b0);
		queue_command(MODE_SCAN, 48'd10, 16'd0, 5'd0, 32'd0, 1'b0);

		clock_ms = 48'd1000;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			hold = (n % 50 == 0);
			clock_ms = clock_ms + $urandom_range(0, 25);
			pick = $urandom_range(0, 99);
			tid = 16'($urandom);
			wide = {16'($urandom), 32'($urandom)};
			ok_slot = (plan_live > 0) ? 5'($urandom_range(0, plan_live - 1)) : 5'd0;
			bad_slot = (plan_live < SLOTS) ? 5'($urandom_range(plan_live, SLOTS - 1)) : ok_slot;
			if (n == 130) begin
				while (plan_live < SLOTS)
					queue_command(MODE_START, clock_ms, 16'($urandom), 5'($urandom),
						$urandom_range(1, 60), 1'b0);
				queue_command(MODE_START, clock_ms, tid, 5'($urandom), 32'd1, 1'b0);
				for (k = 0; k < 8; k++)
					queue_command(MODE_KILL, clock_ms, 16'($urandom),
						5'($urandom_range(0, SLOTS - 1)), $urandom, 1'b0);
				queue_command(MODE_SCAN, clock_ms + 48'd100, tid, 5'($urandom), $urandom, 1'b0);
				hold = 1'b1;
			end
			if (pick < 30) begin
				case ($urandom_range(0, 9))
					0: period = 32'd0;
					1, 2: period = $urandom;
					default: period = $urandom_range(1, 60);
				endcase
				queue_command(MODE_START, clock_ms, tid, 5'($urandom), period, hold);
			end else if (pick < 50) begin
				queue_command(MODE_SCAN, clock_ms, tid, 5'($urandom), $urandom, hold);
			end else if (pick < 62) begin
				queue_command(MODE_KILL, clock_ms, tid, ok_slot, $urandom, hold);
			end else if (pick < 72) begin
				queue_command(MODE_RESTART, clock_ms, tid, ok_slot, $urandom, hold);
			end else if (pick < 80) begin
				period = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40);
				queue_command(MODE_DELAY, clock_ms, tid, ok_slot, period, hold);
			end else if (pick < 87) begin
				queue_command(MODE_FORCE, clock_ms - $urandom_range(0, 30), tid, ok_slot,
					$urandom, hold);
			end else if (pick < 93) begin
				queue_command(slot_modes[$urandom_range(0, 3)], clock_ms, tid, bad_slot,
					$urandom, hold);
			end else if (pick < 96) begin
				queue_command($urandom_range(0, 1) ? MODE_BAD_LO : MODE_BAD_HI, wide, tid,
					5'($urandom), $urandom, hold);
			end else begin
				queue_command(3'($urandom), wide, tid, 5'($urandom), $urandom, hold);
			end
		end

		while (n_accepted != n_planned || n_received != n_expected)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, awaited_results.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
